// ===== design/lcd_scanline_mode_timer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// LCD scanline mode timer assertion macros
// Concurrent assertion shorthands clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LCD_SCANLINE_MODE_TIMER_UNIT_DEFINES_SVH
`define LCD_SCANLINE_MODE_TIMER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LCDSM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcd scanline timer: same-cycle check failed");
`define LCDSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lcd scanline timer: next-cycle check failed");
`else
`define LCDSM_ASSERT_SAME(label, ante, cons)
`define LCDSM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/lcdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD scanline mode timer package
// Mode codes, timing constants and the timer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcdsm_pkg;

    localparam logic [1:0] ModeHblank  = 2'd0;
    localparam logic [1:0] ModeVblank  = 2'd1;
    localparam logic [1:0] ModeOam     = 2'd2;
    localparam logic [1:0] ModeDrawing = 2'd3;

    localparam logic [15:0] OamClocks     = 16'd80;
    localparam logic [15:0] DrawingClocks = 16'd172;
    localparam logic [15:0] HblankClocks  = 16'd204;
    localparam logic [15:0] LineClocks    = 16'd456;
    localparam logic [15:0] AccumMax      = 16'hFFFF;

    localparam logic [7:0] VblankFirst = 8'd144;
    localparam logic [7:0] LastLine    = 8'd153;

    typedef struct packed {
        logic [15:0] accum;
        logic [7:0]  line;
        logic [1:0]  mode;
        logic        match;
    } t_timer_state;

endpackage

// ===== design/lcdsm_step.sv =====
// ----------------------------------------------------------------------------
// LCD scanline mode timer step
// Next-state logic for one item: accumulate, at most one mode change, line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdsm_step import lcdsm_pkg::*; (
    input  t_timer_state i_state,
    input  logic         i_lcd_on,
    input  logic [7:0]   i_elapsed_clocks,
    input  logic [7:0]   i_line_compare,
    output t_timer_state o_state
);

    logic [16:0] sum;
    logic [15:0] accum_sat;
    logic [7:0]  line_inc;

    always_comb begin
        sum       = {1'b0, i_state.accum} + {9'd0, i_elapsed_clocks};
        accum_sat = sum[16] ? AccumMax : sum[15:0];
        line_inc  = i_state.line + 8'd1;
        o_state   = i_state;

        if (!i_lcd_on) begin
            o_state.accum = '0;
            o_state.line  = '0;
            o_state.mode  = ModeHblank;
            o_state.match = (i_line_compare == 8'd0);
        end else begin
            o_state.accum = accum_sat;
            case (i_state.mode)
                ModeOam: begin
                    if (accum_sat >= OamClocks) begin
                        o_state.accum = accum_sat - OamClocks;
                        o_state.mode  = ModeDrawing;
                    end
                end
                ModeDrawing: begin
                    if (accum_sat >= DrawingClocks) begin
                        o_state.accum = accum_sat - DrawingClocks;
                        o_state.mode  = ModeHblank;
                    end
                end
                ModeHblank: begin
                    if (accum_sat >= HblankClocks) begin
                        o_state.accum = accum_sat - HblankClocks;
                        o_state.line  = line_inc;
                        o_state.match = (line_inc == i_line_compare);
                        o_state.mode  = (line_inc == VblankFirst) ? ModeVblank : ModeOam;
                    end
                end
                default: begin
                    if (accum_sat >= LineClocks) begin
                        o_state.accum = accum_sat - LineClocks;
                        // Past the last vblank line the frame restarts at line zero.
                        if (line_inc > LastLine) begin
                            o_state.line  = '0;
                            o_state.mode  = ModeOam;
                            o_state.match = (i_line_compare == 8'd0);
                        end else begin
                            o_state.line  = line_inc;
                            o_state.match = (line_inc == i_line_compare);
                        end
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/lcd_scanline_mode_timer_unit.sv =====
// Datapath: input register, combinational state update, then output register.
// Throughput: one item per cycle while the output is not stalled; the timer state
// register feeds back through a single compare, subtract and increment path, so consecutive items chain.
// Reset (synchronous, active low) clears the timer to line 0 in hblank with the
// coincidence flag low, line_compare to 0, and empties both pipeline registers.
// ----------------------------------------------------------------------------
// LCD scanline mode timer top level
// Input register, state update and output register with valid/stall channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lcd_scanline_mode_timer_unit_defines.svh"

module lcd_scanline_mode_timer_unit import lcdsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_lcd_on,
    input  logic [7:0] i_elapsed_clocks,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_line,
    output logic [1:0] o_mode,
    output logic       o_coincidence
);

    logic         r_in_valid;
    logic         r_in_lcd_on;
    logic [7:0]   r_in_clocks;
    logic [7:0]   r_line_compare;
    t_timer_state r_state;
    t_timer_state n_state;
    logic         r_out_valid;
    logic [7:0]   r_out_line;
    logic [1:0]   r_out_mode;
    logic         r_out_match;
    logic         advance;

    // The pipeline moves whenever the output register is empty or being drained.
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    lcdsm_step u_step (
        .i_state          (r_state),
        .i_lcd_on         (r_in_lcd_on),
        .i_elapsed_clocks (r_in_clocks),
        .i_line_compare   (r_line_compare),
        .o_state          (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_line_compare <= '0;
            r_state        <= '{accum: '0, line: '0, mode: ModeHblank, match: 1'b0};
        end else begin
            if (i_cfg_wr_en) begin
                r_line_compare <= i_cfg_wr_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_lcd_on <= i_lcd_on;
            r_in_clocks <= i_elapsed_clocks;
        end
        if (advance && r_in_valid) begin
            r_out_line  <= n_state.line;
            r_out_mode  <= n_state.mode;
            r_out_match <= n_state.match;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line        = r_out_line;
    assign o_mode        = r_out_mode;
    assign o_coincidence = r_out_match;

    `LCDSM_ASSERT_SAME(a_line_in_frame, 1'b1, r_state.line <= LastLine)
    `LCDSM_ASSERT_SAME(a_vblank_lines, r_state.mode == ModeVblank, r_state.line >= VblankFirst)
    `LCDSM_ASSERT_NEXT(a_display_off_clears, advance && r_in_valid && !r_in_lcd_on,
        r_state.accum == 16'd0 && r_state.line == 8'd0 && r_state.mode == ModeHblank)

endmodule
